/* rtl/lpct_pkg.sv */
// ----------------------------------------------------------------------------
// lpct_pkg
// Shared types and constants of the LRU page cache tag unit.
// ----------------------------------------------------------------------------
package lpct_pkg;

  // Default sizing, handed to the top level parameters
  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned OFFSET_BITS_DEF = 48;

  // Fixed field widths
  localparam int unsigned CAP_BITS  = 5;
  localparam int unsigned SLOT_BITS = 4;

  // Bit positions of the result flags in the output tuser
  localparam int unsigned TUSER_HIT      = 0;
  localparam int unsigned TUSER_INSERTED = 1;
  localparam int unsigned TUSER_EVICTED  = 2;
  localparam int unsigned TUSER_BITS     = 3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } lpct_state_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;    // capture the request offset
    logic match;   // register match, victim and free vectors
    logic update;  // apply the tag/age update and write the result register
  } lpct_cmd_t;

endpackage

/* rtl/lpct_ctrl.sv */
// ----------------------------------------------------------------------------
// lpct_ctrl
// Request sequencer: capture, match and update steps, result register valid.
// ----------------------------------------------------------------------------
module lpct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lpct_pkg::lpct_cmd_t cmd_o
);
  import lpct_pkg::*;

  lpct_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = ST_UPDATE;
      end
      ST_UPDATE: begin
        // Hold until the result register is free or drains this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cmd_o.update) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/lpct_dp.sv */
// ----------------------------------------------------------------------------
// lpct_dp
// Tag/age register file with parallel compare, LRU victim pick and result
// register.
// ----------------------------------------------------------------------------
module lpct_dp #(
  parameter int unsigned MAX_ENTRIES = lpct_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned OFFSET_BITS = lpct_pkg::OFFSET_BITS_DEF,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpct_pkg::lpct_cmd_t           cmd_i,
  input  logic                          cfg_we_i,
  input  logic [lpct_pkg::CAP_BITS-1:0] cfg_wdata_i,
  input  logic [OFFSET_BITS-1:0]        offset_i,
  output logic                          res_hit_o,
  output logic [lpct_pkg::SLOT_BITS-1:0] res_slot_o,
  output logic                          res_inserted_o,
  output logic                          res_evicted_o,
  output logic [OFFSET_BITS-1:0]        res_ev_offset_o,
  output logic [MAX_ENTRIES-1:0]        valid_vec_o,
  output logic [CW-1:0]                 count_o
);
  import lpct_pkg::*;

  localparam int unsigned N    = MAX_ENTRIES;
  localparam int unsigned IW   = $clog2(N);
  localparam int unsigned CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

  // Configuration
  logic [CAP_BITS-1:0] cap_q;
  logic [CMPW-1:0]     cap_eff;

  // Entry state
  logic [OFFSET_BITS-1:0] tag_q [N];
  logic [N-1:0]           valid_q;
  logic [IW-1:0]          age_q [N];
  logic [CW-1:0]          count_q;

  // Request and lookup registers
  logic [OFFSET_BITS-1:0] off_q;
  logic [N-1:0]           match_q, match_d;
  logic [N-1:0]           victim_q, victim_d;
  logic [N-1:0]           free_q, free_d;
  logic                   full_q, enable_q;

  // Update step
  logic                   hit_w, evict_w;
  logic [N-1:0]           sel_w;
  logic [IW-1:0]          slot_w;
  logic [IW-1:0]          hit_age_w;
  logic [OFFSET_BITS-1:0] ev_tag_w;
  logic [N-1:0]           inc_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign cap_eff = (CMPW'(cap_q) > CMPW'(N)) ? CMPW'(N) : CMPW'(cap_q);

  // Lookup: parallel compare, age equal to count-1 marks the LRU entry,
  // lowest clear valid bit marks the free slot
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_d[i]  = valid_q[i] && (tag_q[i] == off_q);
      victim_d[i] = valid_q[i] && (CW'(age_q[i]) == (count_q - CW'(1)));
    end
    free_d = ~valid_q & (valid_q + N'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      off_q <= offset_i;
    end
    if (cmd_i.match) begin
      match_q  <= match_d;
      victim_q <= victim_d;
      free_q   <= free_d;
      full_q   <= CMPW'(count_q) >= cap_eff;
      enable_q <= cap_q != '0;
    end
  end

  // Update: one-hot slot select, encode, age increments
  always_comb begin
    hit_w     = |match_q;
    evict_w   = !hit_w && full_q;
    sel_w     = hit_w ? match_q : (full_q ? victim_q : free_q);
    slot_w    = '0;
    hit_age_w = '0;
    ev_tag_w  = '0;
    for (int i = 0; i < N; i++) begin
      if (sel_w[i]) begin
        slot_w = slot_w | IW'(i);
      end
      if (match_q[i]) begin
        hit_age_w = hit_age_w | age_q[i];
      end
      if (victim_q[i]) begin
        ev_tag_w = ev_tag_w | tag_q[i];
      end
    end
    for (int j = 0; j < N; j++) begin
      inc_w[j] = valid_q[j] && !sel_w[j] && (!hit_w || (age_q[j] < hit_age_w));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < N; i++) begin
        age_q[i] <= '0;
      end
    end else if (cmd_i.update && enable_q) begin
      valid_q <= valid_q | sel_w;
      if (!hit_w && !full_q) begin
        count_q <= count_q + CW'(1);
      end
      for (int i = 0; i < N; i++) begin
        if (sel_w[i]) begin
          age_q[i] <= '0;
        end else if (inc_w[i]) begin
          age_q[i] <= age_q[i] + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && enable_q && !hit_w) begin
      for (int i = 0; i < N; i++) begin
        if (sel_w[i]) begin
          tag_q[i] <= off_q;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (enable_q) begin
        res_hit_o       <= hit_w;
        res_slot_o      <= SLOT_BITS'(slot_w);
        res_inserted_o  <= !hit_w;
        res_evicted_o   <= evict_w;
        res_ev_offset_o <= evict_w ? ev_tag_w : '0;
      end else begin
        res_hit_o       <= 1'b0;
        res_slot_o      <= '0;
        res_inserted_o  <= 1'b0;
        res_evicted_o   <= 1'b0;
        res_ev_offset_o <= '0;
      end
    end
  end

  assign valid_vec_o = valid_q;
  assign count_o     = count_q;

endmodule

/* rtl/lru_page_cache_tags_unit.sv */
// ----------------------------------------------------------------------------
// lru_page_cache_tags_unit
// Fully associative LRU tag store for page offsets.
// ----------------------------------------------------------------------------
// Each input item is one page-read request. An item passes three steps:
// capture of the offset, a registered parallel compare against all entries,
// and the tag/age update that writes the result register, all set by the
// request sequencer; a further item is taken from the cycle after the
// update. A result waiting in the output register does not
// hold off the next request, only its own update step. A hit reports the slot
// and makes that entry most recent; a miss takes the lowest free slot, or
// replaces the least recent entry once the count reaches the capacity and
// reports the evicted offset. Capacity zero turns caching off: requests
// report a plain miss and change nothing. Capacity above MAX_ENTRIES acts as
// MAX_ENTRIES. Write capacity only while no request is in flight.
module lru_page_cache_tags_unit #(
  parameter int unsigned MAX_ENTRIES = lpct_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned OFFSET_BITS = lpct_pkg::OFFSET_BITS_DEF,
  localparam int unsigned IN_DW  = ((OFFSET_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((lpct_pkg::SLOT_BITS + OFFSET_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: capacity
  input  logic                           cfg_we_i,
  input  logic [lpct_pkg::CAP_BITS-1:0]  cfg_wdata_i,
  // Request stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [IN_DW-1:0]               s_axis_tdata_i,  // page_offset
  // Result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [OUT_DW-1:0]              m_axis_tdata_o,  // slot, evicted_offset
  output logic [lpct_pkg::TUSER_BITS-1:0] m_axis_tuser_o  // hit, inserted, evicted
);
  import lpct_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  lpct_cmd_t              cmd;
  logic                   res_hit, res_inserted, res_evicted;
  logic [SLOT_BITS-1:0]   res_slot;
  logic [OFFSET_BITS-1:0] res_ev_offset;
  logic [MAX_ENTRIES-1:0] valid_vec;
  logic [CW-1:0]          count;

  // Sequencer: accepts a request only between items
  lpct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // Tag store, LRU ages and result register
  lpct_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .offset_i        (s_axis_tdata_i[OFFSET_BITS-1:0]),
    .res_hit_o       (res_hit),
    .res_slot_o      (res_slot),
    .res_inserted_o  (res_inserted),
    .res_evicted_o   (res_evicted),
    .res_ev_offset_o (res_ev_offset),
    .valid_vec_o     (valid_vec),
    .count_o         (count)
  );

  // Pack slot in the low bits, evicted offset above, zero fill to bytes
  assign m_axis_tdata_o = OUT_DW'({res_ev_offset, res_slot});

  always_comb begin
    m_axis_tuser_o                 = '0;
    m_axis_tuser_o[TUSER_HIT]      = res_hit;
    m_axis_tuser_o[TUSER_INSERTED] = res_inserted;
    m_axis_tuser_o[TUSER_EVICTED]  = res_evicted;
  end

`ifndef NO_ASSERTIONS
  // Fill count tracks the number of valid entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count))
    else $error("entry count out of step with valid bits");

  // Hit and insert exclude each other; eviction only comes with an insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(res_hit && res_inserted) && (res_inserted || !res_evicted))
    else $error("inconsistent result flags");

  // Evicted offset reads zero without an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !res_evicted) |-> (res_ev_offset == '0))
    else $error("evicted offset set without eviction");
`endif

endmodule

/* tb/lru_page_cache_tags_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_page_cache_tags_unit_test
// Self-checking bench for the LRU page cache tag unit.
// ----------------------------------------------------------------------------
// Requests go in over the slave stream, one page offset per item. A local
// model of the tag store predicts hit, slot, insert, eviction and the evicted
// offset for every accepted request. A checker compares each result against
// the oldest prediction. The run starts with directed cases: caching off, a
// small fill with hits and an eviction, capacity lowered below the count,
// clamping above the entry count. Random phases at several capacities follow,
// plus one phase where the result side holds off so the block stalls.
// ----------------------------------------------------------------------------
module lru_page_cache_tags_unit_test;
  import lpct_pkg::*;

  localparam int unsigned NUM_ENTRIES = MAX_ENTRIES_DEF;
  localparam int unsigned OFF_BITS    = OFFSET_BITS_DEF;
  localparam int unsigned IN_W        = ((OFF_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W       = ((SLOT_BITS + OFF_BITS + 7) / 8) * 8;
  localparam logic [OFF_BITS-1:0] OFFSET_MAX = '1;

  // Receiver stall patterns
  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_e;

  // One predicted or observed lookup result
  typedef struct packed {
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
    logic                 inserted;
    logic                 evicted;
    logic [OFF_BITS-1:0]  ev_off;
  } lookup_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CAP_BITS-1:0]   cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;   // page_offset
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;   // slot, evicted_offset
  logic [TUSER_BITS-1:0] m_tuser;   // hit, inserted, evicted

  // Tag store as the bench sees it
  logic [OFF_BITS-1:0] tag_mem   [NUM_ENTRIES];
  bit                  valid_mem [NUM_ENTRIES];
  int                  age_mem   [NUM_ENTRIES];
  int                  entry_total;
  int                  cap_setting;

  lookup_result_t expected_lookups[$];

  int mismatch_count;
  int results_checked;
  int hits_seen;
  int evictions_seen;
  int plain_misses_seen;

  // Sender and receiver pacing
  int burst_left;
  bit sender_steady;
  int hold_request;
  int hold_left;
  int mode_left;
  rx_mode_e rx_mode;
  int rx_tick;

  lru_page_cache_tags_unit #(
    .MAX_ENTRIES(NUM_ENTRIES),
    .OFFSET_BITS(OFF_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Give up after a generous fixed time
  initial begin
    #2_000_000;
    $display("lru_page_cache_tags_unit_test: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Make slot s most recent; valid entries younger than limit age by one.
  function automatic void make_recent(int s, int limit);
    for (int j = 0; j < NUM_ENTRIES; j++) begin
      if (j != s && valid_mem[j] && age_mem[j] < limit) age_mem[j]++;
    end
    age_mem[s] = 0;
  endfunction

  function automatic lookup_result_t predict_lookup(logic [OFF_BITS-1:0] off);
    lookup_result_t r;
    int eff_cap;
    int pick;
    int oldest;
    bit found;
    bit have;
    r = '0;
    pick = 0;
    oldest = 0;
    found = 0;
    have = 0;
    eff_cap = (cap_setting > NUM_ENTRIES) ? NUM_ENTRIES : cap_setting;
    // Capacity zero: no lookup and no change
    if (eff_cap == 0) return r;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (!found && valid_mem[i] && tag_mem[i] == off) begin
        found = 1;
        pick = i;
      end
    end
    if (found) begin
      r.hit  = 1'b1;
      r.slot = pick[SLOT_BITS-1:0];
      make_recent(pick, age_mem[pick]);
      return r;
    end
    // Full (or over capacity after a lowering): drop the least recent entry
    if (entry_total >= eff_cap) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (valid_mem[i] && (!have || age_mem[i] > oldest)) begin
          have = 1;
          oldest = age_mem[i];
          pick = i;
        end
      end
      if (have) begin
        r.evicted = 1'b1;
        r.ev_off = tag_mem[pick];
        valid_mem[pick] = 0;
        entry_total--;
      end
    end
    // Otherwise take the lowest free slot
    if (!have) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (!have && !valid_mem[i]) begin
          have = 1;
          pick = i;
        end
      end
    end
    if (have) begin
      r.inserted = 1'b1;
      r.slot = pick[SLOT_BITS-1:0];
      tag_mem[pick] = off;
      valid_mem[pick] = 1;
      make_recent(pick, 255);
      entry_total++;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : check_results
    lookup_result_t got;
    lookup_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.hit      = m_tuser[TUSER_HIT];
      got.inserted = m_tuser[TUSER_INSERTED];
      got.evicted  = m_tuser[TUSER_EVICTED];
      got.slot     = m_tdata[SLOT_BITS-1:0];
      got.ev_off   = m_tdata[SLOT_BITS +: OFF_BITS];
      if (expected_lookups.size() == 0) begin
        note_mismatch($sformatf("result with no request pending: hit=%0b slot=%0d",
                                got.hit, got.slot));
      end else begin
        want = expected_lookups.pop_front();
        results_checked++;
        if (want.hit) hits_seen++;
        if (want.evicted) evictions_seen++;
        if (!want.hit && !want.inserted) plain_misses_seen++;
        if (got.hit !== want.hit || got.slot !== want.slot ||
            got.inserted !== want.inserted || got.evicted !== want.evicted ||
            got.ev_off !== want.ev_off) begin
          note_mismatch($sformatf(
            "lookup %0d: exp hit=%0b slot=%0d ins=%0b ev=%0b ev_off=%h, got %0b %0d %0b %0b %h",
            results_checked, want.hit, want.slot, want.inserted, want.evicted,
            want.ev_off, got.hit, got.slot, got.inserted, got.evicted, got.ev_off));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stalls on its own pattern, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    rx_tick++;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(RX_STEADY, RX_PATTERN));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_STEADY:  m_tready <= 1'b1;
        RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE:  m_tready <= ($urandom_range(0, 3) == 0);
        default:    m_tready <= (rx_tick % 5 != 0) && (rx_tick % 7 != 3);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender and configuration helpers
  // --------------------------------------------------------------------------

  function automatic logic [OFF_BITS-1:0] rand_offset();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[OFF_BITS-1:0];
  endfunction

  // Offer one request; bursts of random length with random gaps in between.
  task automatic send_request(logic [OFF_BITS-1:0] off);
    int gap;
    if (!sender_steady && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'(off);
    do @(posedge clk_i); while (!s_tready);
    expected_lookups.insert(expected_lookups.size(), predict_lookup(off));
    if (burst_left > 0) burst_left--;
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_capacity(int value);
    wait_idle();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= CAP_BITS'(value);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cap_setting = value;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Capacity is zero out of reset: every request is a plain miss.
  task automatic test_caching_disabled();
    send_request('0);
    send_request(OFFSET_MAX);
  endtask

  // Fill four entries, hit two of them, then force an eviction.
  task automatic test_fill_and_hit();
    write_capacity(4);
    send_request('0);
    send_request(OFFSET_MAX);
    send_request(48'h0000_0000_1230);
    send_request(48'hA5A5_5A5A_0ABC);
    send_request('0);
    send_request(OFFSET_MAX);
    send_request(48'h0000_0000_5550);   // evicts the least recent entry
  endtask

  // Lower capacity below the count, switch caching off, then clamp above 16.
  task automatic test_capacity_changes();
    write_capacity(2);
    send_request(48'h0000_7777_0000);   // one eviction, count stays at four
    send_request(OFFSET_MAX);           // hits survive the lowering
    send_request(48'h0000_7777_1000);
    write_capacity(0);
    send_request(OFFSET_MAX);           // kept entry, but caching is off
    write_capacity(31);
    send_request(OFFSET_MAX);           // hits again once capacity is back
    send_request(48'h0000_7777_1000);
  endtask

  // Random offsets drawn mostly from a small pool so hits and evictions mix.
  task automatic test_random_traffic(int cap, int n_items, int pool_size);
    logic [OFF_BITS-1:0] pool[$];
    logic [OFF_BITS-1:0] off;
    write_capacity(cap);
    for (int i = 0; i < pool_size; i++) pool.insert(pool.size(), rand_offset());
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 4) == 0) off = rand_offset();
      else off = pool[$urandom_range(0, pool_size - 1)];
      send_request(off);
    end
  endtask

  // Hold the result side off for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    logic [OFF_BITS-1:0] pool[$];
    write_capacity(5);
    for (int i = 0; i < 7; i++) pool.insert(pool.size(), rand_offset());
    hold_request = 80;
    sender_steady = 1;
    for (int i = 0; i < 24; i++) send_request(pool[$urandom_range(0, 6)]);
    sender_steady = 0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    entry_total   = 0;
    cap_setting   = 0;
    burst_left    = 0;
    sender_steady = 0;
    hold_request  = 0;
    hold_left     = 0;
    mode_left     = 0;
    rx_mode       = RX_STEADY;
    rx_tick       = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tag_mem[i]   = '0;
      valid_mem[i] = 0;
      age_mem[i]   = 0;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_caching_disabled();
    test_fill_and_hit();
    test_capacity_changes();
    test_random_traffic(16, 100, 20);
    test_random_traffic(3, 50, 5);
    test_output_backpressure();
    test_random_traffic(1, 40, 3);
    test_random_traffic(17, 60, 18);
    test_random_traffic(0, 20, 4);
    test_random_traffic(8, 60, 12);
    test_random_traffic(31, 40, 24);

    // Drain, then leave room for any stray result to show up
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (expected_lookups.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_lookups.size()));

    $display("Checked %0d lookups at capacities 0 to 31: %0d hits, %0d evictions,",
             results_checked, hits_seen, evictions_seen);
    $display("%0d uncached misses, including a long output stall; %0d mismatches.",
             plain_misses_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("lru_page_cache_tags_unit_test: PASS");
    end else begin
      $display("lru_page_cache_tags_unit_test: FAIL");
    end
    $finish;
  end

endmodule
